// ===== rtl/kdhd_pkg.sv =====
// ----------------------------------------------------------------------------
// kdhd_pkg
// shared types and constants for the key debounce and hold detector
// ----------------------------------------------------------------------------
package kdhd_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_PRESS_SETTLE   = 2'd0;
  localparam logic [1:0] CFG_RELEASE_SETTLE = 2'd1;
  localparam logic [1:0] CFG_HOLD_TIME      = 2'd2;
  localparam logic [1:0] CFG_STARTUP_DL     = 2'd3;

  // reset values of the registers
  localparam logic [15:0] PRESS_SETTLE_RST   = 16'd50;
  localparam logic [15:0] RELEASE_SETTLE_RST = 16'd50;
  localparam logic [15:0] HOLD_TIME_RST      = 16'd900;
  localparam logic [31:0] STARTUP_DL_RST     = 32'd500;

  // external state codes
  localparam logic [2:0] CODE_RELEASED     = 3'd0;
  localparam logic [2:0] CODE_PRESS_WAIT   = 3'd1;
  localparam logic [2:0] CODE_PRESSED      = 3'd2;
  localparam logic [2:0] CODE_HOLD         = 3'd3;
  localparam logic [2:0] CODE_WAIT_RELEASE = 3'd4;

  typedef enum logic [4:0] {
    ST_RELEASED     = 5'b00001,
    ST_PRESS_WAIT   = 5'b00010,
    ST_PRESSED      = 5'b00100,
    ST_HOLD         = 5'b01000,
    ST_WAIT_RELEASE = 5'b10000
  } key_state_e;

  typedef struct packed {
    logic [15:0] press_settle;
    logic [15:0] release_settle;
    logic [15:0] hold_time;
    logic [31:0] startup_dl;
  } kdhd_cfg_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       press_event;
    logic       locked;
  } kdhd_res_t;

  function automatic logic [2:0] state_code(key_state_e st);
    logic [2:0] code;
    case (st)
      ST_RELEASED:     code = CODE_RELEASED;
      ST_PRESS_WAIT:   code = CODE_PRESS_WAIT;
      ST_PRESSED:      code = CODE_PRESSED;
      ST_HOLD:         code = CODE_HOLD;
      ST_WAIT_RELEASE: code = CODE_WAIT_RELEASE;
      default:         code = CODE_RELEASED;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/key_debounce_hold_detector.sv =====
// ----------------------------------------------------------------------------
// key_debounce_hold_detector
// debounce and long-press detection for one key, one poll per beat
// ----------------------------------------------------------------------------
// path: an accepted input beat passes the input register, then the result register
// throughput: one poll per cycle while the result channel is not stalled, set by the
// state update between the input register and the result register
// reset: state machine released, press timestamp zero, startup lock set,
// configuration registers at their defaults; no clearing pass
module key_debounce_hold_detector import kdhd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,

  // poll input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        key_level_i,
  input  logic [31:0] now_time_i,

  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  key_state_code_o,
  output logic        press_event_o,
  output logic        startup_locked_o
);

  kdhd_cfg_t cfg;
  kdhd_res_t res;

  // input register
  logic        in_vld_q;
  logic        key_q;
  logic [31:0] now_q;

  // result register
  logic        out_vld_q;
  kdhd_res_t   res_q;

  logic out_load;
  logic in_load;

  // result register takes a new beat when empty or being drained
  assign out_load = !out_vld_q || !out_stall_i;
  // input register frees up when its beat moves on to the result register
  assign in_load  = !in_vld_q || out_load;

  assign in_stall_o = !in_load;

  kdhd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // state only advances when the poll actually lands in the result register
  kdhd_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_vld_q && out_load),
    .key_i  (key_q),
    .now_i  (now_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_load) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      key_q <= key_level_i;
      now_q <= now_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_vld_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign key_state_code_o = res_q.state_code;
  assign press_event_o    = res_q.press_event;
  assign startup_locked_o = res_q.locked;

endmodule

// ===== rtl/kdhd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kdhd_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module kdhd_cfg_regs import kdhd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output kdhd_cfg_t   cfg_o
);

  kdhd_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_settle   <= PRESS_SETTLE_RST;
      cfg_q.release_settle <= RELEASE_SETTLE_RST;
      cfg_q.hold_time      <= HOLD_TIME_RST;
      cfg_q.startup_dl     <= STARTUP_DL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESS_SETTLE:   cfg_q.press_settle   <= cfg_wdata_i[15:0];
        CFG_RELEASE_SETTLE: cfg_q.release_settle <= cfg_wdata_i[15:0];
        CFG_HOLD_TIME:      cfg_q.hold_time      <= cfg_wdata_i[15:0];
        CFG_STARTUP_DL:     cfg_q.startup_dl     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/kdhd_step.sv =====
// ----------------------------------------------------------------------------
// kdhd_step
// key state machine, press timestamp and startup lock, one poll a cycle while step_i is high
// ----------------------------------------------------------------------------
module kdhd_step import kdhd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        key_i,
  input  logic [31:0] now_i,
  input  kdhd_cfg_t   cfg_i,
  output kdhd_res_t   res_o
);

  localparam int unsigned CmpWidth = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  key_state_e            state_q, state_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic                  lock_q, lock_d;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  past_dl;

  assign now_t   = TIME_WIDTH'(now_i);
  assign elapsed = now_t - start_q;
  assign past_dl = CmpWidth'(now_t) > CmpWidth'(cfg_i.startup_dl);

  always_comb begin
    state_d = state_q;
    start_d = start_q;
    case (state_q)
      ST_RELEASED: begin
        if (key_i) begin
          state_d = ST_PRESS_WAIT;
          start_d = now_t;
        end
      end
      ST_PRESS_WAIT: begin
        if (elapsed > TIME_WIDTH'(cfg_i.press_settle)) begin
          state_d = key_i ? ST_PRESSED : ST_RELEASED;
        end
      end
      ST_PRESSED: begin
        if (!key_i) begin
          state_d = ST_WAIT_RELEASE;
          start_d = now_t;
        end else if (elapsed > TIME_WIDTH'(cfg_i.hold_time)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!key_i) begin
          state_d = ST_WAIT_RELEASE;
          start_d = now_t;
        end
      end
      ST_WAIT_RELEASE: begin
        if (elapsed > TIME_WIDTH'(cfg_i.release_settle)) begin
          state_d = ST_RELEASED;
        end
      end
      default: begin
        // unreachable codes behave as released
        state_d = ST_RELEASED;
        if (key_i) begin
          state_d = ST_PRESS_WAIT;
          start_d = now_t;
        end
      end
    endcase
  end

  assign lock_d = lock_q & ~past_dl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RELEASED;
      start_q <= '0;
      lock_q  <= 1'b1;
    end else if (step_i) begin
      state_q <= state_d;
      start_q <= start_d;
      lock_q  <= lock_d;
    end
  end

  assign res_o.state_code  = state_code(state_d);
  assign res_o.press_event = past_dl && (state_q == ST_PRESSED) && !key_i;
  assign res_o.locked      = lock_d;

endmodule

// ===== verif/key_debounce_hold_detector_tb.sv =====
// ----------------------------------------------------------------------------
// key_debounce_hold_detector_tb
// self-checking testbench for the key debounce and hold detector
// ----------------------------------------------------------------------------
// polls go in through the valid/stall input channel and are predicted as they
// are accepted. every result beat is compared field by field with the oldest
// prediction. a short directed part walks the state machine, the startup
// lock and the time wrap. random press trains with bounce and time jumps then
// run under several timing settings, with random gaps and stalls, one quiet
// stretch and one long receiver hold-off.
// ----------------------------------------------------------------------------
module key_debounce_hold_detector_tb import kdhd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // clock and reset
  logic        clk_i;
  logic        rst_n;

  // configuration port
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  // poll channel
  logic        in_valid;
  logic        in_stall;
  logic        key_level;
  logic [31:0] now_time;

  // result channel
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  key_state_code;
  logic        press_event;
  logic        startup_locked;

  // predictor state, mirrors the block after every accepted poll
  kdhd_cfg_t   timing;
  logic [2:0]  key_phase;
  logic [31:0] press_stamp;
  logic        lock_sticky;

  // predicted result beats, oldest first
  kdhd_res_t   predicted_polls[$];
  kdhd_res_t   want;
  int unsigned mismatches;

  // idling controls shared by the sender, the receiver and the tests
  bit          gaps_on;
  bit          stalls_on;
  int unsigned holdoff_len;
  int unsigned held;

  // running millisecond time used by the random press trains
  logic [31:0] clock_ms;

  key_debounce_hold_detector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .key_level_i      (key_level),
    .now_time_i       (now_time),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .key_state_code_o (key_state_code),
    .press_event_o    (press_event),
    .startup_locked_o (startup_locked)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard limit on the run, far beyond the slowest correct run
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one poll of the key machine; elapsed time wraps at 32 bits and every
  // compare against a settle or hold time is strict
  function automatic kdhd_res_t debounce_step(input logic key, input logic [31:0] now);
    kdhd_res_t   res;
    logic [2:0]  prev;
    logic [31:0] since;
    prev  = key_phase;
    since = now - press_stamp;
    case (key_phase)
      CODE_PRESS_WAIT: begin
        if (since > {16'd0, timing.press_settle})
          key_phase = key ? CODE_PRESSED : CODE_RELEASED;
      end
      CODE_PRESSED: begin
        if (!key) begin
          key_phase   = CODE_WAIT_RELEASE;
          press_stamp = now;
        end else if (since > {16'd0, timing.hold_time}) begin
          key_phase = CODE_HOLD;
        end
      end
      CODE_HOLD: begin
        // leaving hold never raises a press event
        if (!key) begin
          key_phase   = CODE_WAIT_RELEASE;
          press_stamp = now;
        end
      end
      CODE_WAIT_RELEASE: begin
        if (since > {16'd0, timing.release_settle})
          key_phase = CODE_RELEASED;
      end
      default: begin
        if (key) begin
          key_phase   = CODE_PRESS_WAIT;
          press_stamp = now;
        end else begin
          key_phase = CODE_RELEASED;
        end
      end
    endcase
    res.press_event = 1'b0;
    // past the deadline the lock clears for good and short presses count
    if (now > timing.startup_dl) begin
      lock_sticky     = 1'b0;
      res.press_event = (prev == CODE_PRESSED) && (key_phase == CODE_WAIT_RELEASE);
    end
    res.state_code = key_phase;
    res.locked     = lock_sticky;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and receiver stalls
  // ---------------------------------------------------------------------------

  // every accepted result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_polls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: code %0d event %0b locked %0b",
                   key_state_code, press_event, startup_locked);
      end else begin
        want = predicted_polls.pop_front();
        if (key_state_code !== want.state_code || press_event !== want.press_event ||
            startup_locked !== want.locked) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected code %0d event %0b locked %0b, ",
                      "got code %0d event %0b locked %0b"},
                     want.state_code, want.press_event, want.locked,
                     key_state_code, press_event, startup_locked);
        end
      end
    end
  end

  // receiver: random stalls, or a long counted hold-off when one is asked for
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_len != 0) begin
        out_stall <= 1'b1;
        for (held = 0; held < holdoff_len; held++) @(posedge clk_i);
        holdoff_len = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= stalls_on && ($urandom_range(99) < 22);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared driving tasks
  // ---------------------------------------------------------------------------

  // offer one poll beat, wait for it to be taken, then predict its result
  task automatic send_poll(input logic key, input logic [31:0] now);
    int unsigned gap;
    if (gaps_on && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    key_level <= key;
    now_time  <= now;
    do @(posedge clk_i); while (in_stall);
    predicted_polls.push_back(debounce_step(key, now));
  endtask

  // stop offering and wait until every predicted beat has come back
  task automatic drain_polls();
    in_valid <= 1'b0;
    while (predicted_polls.size() != 0) @(posedge clk_i);
    // then idle before touching the registers
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PRESS_SETTLE:   timing.press_settle   = data[15:0];
      CFG_RELEASE_SETTLE: timing.release_settle = data[15:0];
      CFG_HOLD_TIME:      timing.hold_time      = data[15:0];
      default:            timing.startup_dl     = data;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [15:0] press, input logic [15:0] release_ms,
                            input logic [15:0] hold, input logic [31:0] deadline);
    write_reg(CFG_PRESS_SETTLE, {16'd0, press});
    write_reg(CFG_RELEASE_SETTLE, {16'd0, release_ms});
    write_reg(CFG_HOLD_TIME, {16'd0, hold});
    write_reg(CFG_STARTUP_DL, deadline);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default timing after reset: settle 50, hold 900, deadline 500
  task automatic test_reset_defaults();
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd10);           // press wait starts
    send_poll(1'b1, 32'd60);           // exactly the settle time, still waiting
    send_poll(1'b1, 32'd61);           // pressed
    send_poll(1'b0, 32'd100);          // short press before startup, no event
    send_poll(1'b0, 32'd151);          // back to released
    send_poll(1'b1, 32'd600);          // past the deadline, lock clears
    send_poll(1'b1, 32'd651);
    send_poll(1'b1, 32'd1552);         // held long enough, hold
    send_poll(1'b0, 32'd1560);         // release from hold, no event
    send_poll(1'b0, 32'd1611);
    send_poll(1'b1, 32'd1700);
    send_poll(1'b1, 32'd1751);
    send_poll(1'b0, 32'd1800);         // short press after startup, event
    send_poll(1'b0, 32'd1851);
    send_poll(1'b1, 32'd1900);
    send_poll(1'b0, 32'd1960);         // bounce, settle runs out with key low
    send_poll(1'b1, 32'd2000);
    send_poll(1'b0, 32'd2010);         // key low inside the settle window
    send_poll(1'b0, 32'd2051);
    send_poll(1'b0, 32'hFFFF_FFFF);    // top of the time range
    send_poll(1'b1, 32'hFFFF_FFF0);
    send_poll(1'b1, 32'd40);           // elapsed across the wrap
    send_poll(1'b0, 32'd41);           // time below the deadline again, no event
    send_poll(1'b0, 32'd92);
    drain_polls();
  endtask

  // zero and full-scale register values
  task automatic test_register_extremes();
    set_timing(16'd0, 16'd0, 16'd0, 32'd0);
    send_poll(1'b1, 32'd5);
    send_poll(1'b1, 32'd5);            // zero elapsed never beats a zero settle
    send_poll(1'b1, 32'd6);
    send_poll(1'b1, 32'd6);
    send_poll(1'b1, 32'd7);            // still in hold, reached on the poll before with the zero hold time
    send_poll(1'b0, 32'd7);
    send_poll(1'b0, 32'd7);
    send_poll(1'b0, 32'd8);
    send_poll(1'b1, 32'd9);
    send_poll(1'b1, 32'd10);
    send_poll(1'b0, 32'd10);           // short press with zero deadline
    drain_polls();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'h8000_0000);
    send_poll(1'b1, 32'h8000_FFFF);    // exactly the settle time
    send_poll(1'b1, 32'h8001_0000);
    send_poll(1'b1, 32'h8001_FFFF);
    send_poll(1'b1, 32'h8002_0000);    // still in hold, reached on the poll before past the full hold time
    send_poll(1'b0, 32'h8002_0001);
    send_poll(1'b0, 32'h8003_0000);
    send_poll(1'b0, 32'h8003_0001);
    drain_polls();
  endtask

  // press trains: runs of one level, with bounce, zero steps and time jumps
  task automatic test_press_trains(input int n_polls, input int unsigned step_max);
    int   sent;
    int   run_len;
    logic level;
    sent  = 0;
    level = 1'b0;
    while (sent < n_polls) begin
      level   = ~level;
      run_len = $urandom_range(1, 10);
      repeat (run_len) begin
        if ($urandom_range(99) < 4)
          clock_ms = $urandom();
        else
          clock_ms = clock_ms + $urandom_range(0, step_max);
        send_poll(($urandom_range(99) < 8) ? ~level : level, clock_ms);
        sent++;
      end
    end
    drain_polls();
  endtask

  // a long receiver hold-off while polls keep coming, so the input backs up
  task automatic test_holdoff_pressure();
    set_timing(16'd10, 16'd10, 16'd40, clock_ms);
    holdoff_len = 150;
    test_press_trains(40, 15);
  endtask

  // a stretch with no gaps and no stalls at all
  task automatic test_quiet_stretch();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_timing(16'd8, 16'd12, 16'd50, clock_ms + 32'd100);
    test_press_trains(150, 12);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_PRESS_SETTLE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    key_level   = 1'b0;
    now_time    = '0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    holdoff_len = 0;
    mismatches  = 0;
    clock_ms    = 32'd3000;
    // predictor at its reset state
    timing.press_settle   = PRESS_SETTLE_RST;
    timing.release_settle = RELEASE_SETTLE_RST;
    timing.hold_time      = HOLD_TIME_RST;
    timing.startup_dl     = STARTUP_DL_RST;
    key_phase   = CODE_RELEASED;
    press_stamp = '0;
    lock_sticky = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();

    // mid-range timing with the deadline a little ahead
    clock_ms = $urandom();
    set_timing(16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
               16'($urandom_range(20, 120)), clock_ms + $urandom_range(0, 400));
    test_press_trains(150, 25);

    // zero settle times, tiny steps
    set_timing(16'd0, 16'd0, 16'($urandom_range(0, 10)), $urandom());
    test_press_trains(150, 3);

    // deadline out of reach, no press events at all
    set_timing(16'($urandom_range(5, 40)), 16'($urandom_range(5, 40)),
               16'($urandom_range(30, 150)), 32'hFFFF_FFFF);
    test_press_trains(150, 40);

    test_quiet_stretch();
    test_holdoff_pressure();

    // time running through the wrap
    clock_ms = 32'hFFFF_FF00;
    set_timing(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
               16'($urandom_range(10, 80)),
               $urandom_range(0, 1) ? 32'hFFFF_FF80 : 32'd100);
    test_press_trains(150, 20);

    // full-scale timing with coarse steps
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, clock_ms);
    test_press_trains(150, 40000);

    repeat (8) @(posedge clk_i);
    if (predicted_polls.size() != 0) begin
      mismatches += predicted_polls.size();
      $display("%0d result beats never arrived", predicted_polls.size());
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kdhd_pkg.sv
rtl/kdhd_cfg_regs.sv
rtl/kdhd_step.sv
rtl/key_debounce_hold_detector.sv
verif/key_debounce_hold_detector_tb.sv
